### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the checker in ptpc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define PTPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define PTPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define PTPC_ASSERT_NEXT_NR(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### sv/ptpc_pkg.sv
// ----------------------------------------------------------------------------
// ptpc_pkg
// Shared constants, codes and helpers of the planar tile pixel codec.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ptpc_pkg;

  localparam int ROM_BYTES    = 65536;
  localparam int ROM_AW       = $clog2(ROM_BYTES);
  localparam int BIT_AW       = ROM_AW + 3;
  localparam int MAX_TILE_DIM = 32;
  localparam int MAX_PLANES   = 8;
  localparam int DIM_IDX_W    = $clog2(MAX_TILE_DIM);
  localparam int PLANE_IDX_W  = $clog2(MAX_PLANES);

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 19;

  localparam logic [CFG_IDX_W-1:0] REG_PLANE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_STRIDE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BYTE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW4_QUIRK  = 3'd6;

  localparam logic [1:0] CMD_LOAD_ROM    = 2'd0;
  localparam logic [1:0] CMD_LOAD_LAYOUT = 2'd1;
  localparam logic [1:0] CMD_READ        = 2'd2;
  localparam logic [1:0] CMD_WRITE       = 2'd3;

  localparam logic [1:0] TSEL_COL   = 2'd0;
  localparam logic [1:0] TSEL_ROW   = 2'd1;
  localparam logic [1:0] TSEL_PLANE = 2'd2;

  localparam logic [2:0] ORI_NONE  = 3'd0;
  localparam logic [2:0] ORI_FLIPX = 3'd1;
  localparam logic [2:0] ORI_FLIPY = 3'd2;
  localparam logic [2:0] ORI_R180  = 3'd3;
  localparam logic [2:0] ORI_R90   = 3'd4;
  localparam logic [2:0] ORI_R270  = 3'd5;

  localparam logic [4:0] QUIRK_ROW   = 5'd4;
  localparam logic [5:0] QUIRK_SHIFT = 6'd4;

  function automatic logic [5:0] clamp_dim(input logic [5:0] v);
    if (v == 6'd0) return 6'd1;
    if (v > 6'(MAX_TILE_DIM)) return 6'(MAX_TILE_DIM);
    return v;
  endfunction

  function automatic logic [3:0] clamp_planes(input logic [3:0] v);
    if (v == 4'd0) return 4'd1;
    if (v > 4'(MAX_PLANES)) return 4'(MAX_PLANES);
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/ptpc_if.sv
// ----------------------------------------------------------------------------
// ptpc_in_if / ptpc_out_if
// Valid/ready channels for commands and pixel results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ptpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  table_select;
  logic [15:0] location;
  logic [18:0] load_data;
  logic [9:0]  tile_index;
  logic [4:0]  col;
  logic [4:0]  row;
  logic [7:0]  pixel_in;

  modport source (
    output valid, command, table_select, location, load_data, tile_index, col, row,
           pixel_in,
    input  ready
  );
  modport sink (
    input  valid, command, table_select, location, load_data, tile_index, col, row,
           pixel_in,
    output ready
  );
endinterface

interface ptpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_out;
  logic [4:0] dest_x;
  logic [4:0] dest_y;

  modport source (output valid, pixel_out, dest_x, dest_y, input ready);
  modport sink (input valid, pixel_out, dest_x, dest_y, output ready);
endinterface

`default_nettype wire

### sv/planar_tile_pixel_codec_core.sv
// ----------------------------------------------------------------------------
// planar_tile_pixel_codec_core
// Bit-plane tile graphics store: loads ROM bytes and layout tables, reads
// and writes single pixels through a shared address adder.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one command per transfer: ROM byte load, layout entry load,
//   pixel read or pixel write. out_ch returns exactly one result per command.
//   cfg_we/cfg_index/cfg_data write the layout registers; write them only
//   while no command is in flight.
// Sequencing:
//   loads go straight to the done state. Reads and writes run the row 4
//   quirk remainder step when it applies, then the address adds, then one
//   pass per plane: an address add, a ROM read and a bit update on the
//   single ROM port. in_ch.ready is high only while the sequencer is idle.
// Reset:
//   rst_n clears the sequencer, the output valid and the registers to their
//   defaults. ROM and layout tables hold undefined data until loaded.
// Stalls:
//   a result waits in the output register while out_ch.ready is low; the
//   next command may be taken meanwhile and its result waits behind it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module planar_tile_pixel_codec_core import ptpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ptpc_in_if.sink               in_ch,
  ptpc_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MOD   = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_ADDP  = 4'd3;
  localparam logic [3:0] S_ADDC  = 4'd4;
  localparam logic [3:0] S_ADDR  = 4'd5;
  localparam logic [3:0] S_PADDR = 4'd6;
  localparam logic [3:0] S_PRD   = 4'd7;
  localparam logic [3:0] S_PUSE  = 4'd8;
  localparam logic [3:0] S_DONE  = 4'd9;

  logic [3:0]        plane_count_r;
  logic [18:0]       stride_r;
  logic [15:0]       base_r;
  logic [5:0]        tw_r;
  logic [5:0]        th_r;
  logic [2:0]        orient_r;
  logic              quirk_r;

  logic [3:0]        state_r, state_nxt;
  logic [1:0]        cmd_r;
  logic [9:0]        tile_r;
  logic [4:0]        x_r;
  logic [4:0]        y_r;
  logic [7:0]        pin_r;
  logic [DIM_IDX_W-1:0]   ci_r;
  logic [5:0]        rem_r;
  logic [2:0]        k_r;
  logic [BIT_AW-1:0] acc_r;
  logic [BIT_AW-1:0] prod_r;
  logic [BIT_AW-1:0] addr_r;
  logic [PLANE_IDX_W-1:0] p_r;
  logic [7:0]        pix_r;
  logic [7:0]        rom_q_r;

  logic              out_valid_r;
  logic [7:0]        out_pix_r;
  logic [4:0]        out_dx_r;
  logic [4:0]        out_dy_r;

  logic [18:0]       col_tab  [MAX_TILE_DIM];
  logic [18:0]       row_tab  [MAX_TILE_DIM];
  logic [18:0]       plane_tab[MAX_PLANES];
  logic [7:0]        rom_mem  [ROM_BYTES];

  logic              in_xfer;
  logic [3:0]        planes;
  logic [5:0]        w_eff;
  logic [5:0]        h_eff;
  logic [28:0]       mult_full;
  logic [BIT_AW-1:0] add_b;
  logic [BIT_AW-1:0] sum;
  logic [10:0]       trial;
  logic [5:0]        rem_step;
  logic [3:0]        sh_full;
  logic [2:0]        sh;
  logic [2:0]        bit_pos;
  logic [7:0]        mod_byte;
  logic              last_plane;
  logic              out_load;
  logic              rom_we;
  logic [ROM_AW-1:0] rom_wa;
  logic [7:0]        rom_wd;
  logic [4:0]        dx;
  logic [4:0]        dy;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign planes      = clamp_planes(plane_count_r);
  assign w_eff       = clamp_dim(tw_r);
  assign h_eff       = clamp_dim(th_r);

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_count_r <= 4'd1;
      stride_r      <= 19'd64;
      base_r        <= 16'd0;
      tw_r          <= 6'd8;
      th_r          <= 6'd8;
      orient_r      <= ORI_NONE;
      quirk_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PLANE_COUNT: plane_count_r <= cfg_data[3:0];
        REG_TILE_STRIDE: stride_r      <= cfg_data[18:0];
        REG_BASE_BYTE:   base_r        <= cfg_data[15:0];
        REG_TILE_WIDTH:  tw_r          <= cfg_data[5:0];
        REG_TILE_HEIGHT: th_r          <= cfg_data[5:0];
        REG_ORIENTATION: orient_r      <= cfg_data[2:0];
        REG_ROW4_QUIRK:  quirk_r       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // layout tables
  always_ff @(posedge clk) begin
    if (in_xfer && in_ch.command == CMD_LOAD_LAYOUT) begin
      if (in_ch.table_select == TSEL_COL && in_ch.location[15:DIM_IDX_W] == '0) begin
        col_tab[in_ch.location[DIM_IDX_W-1:0]] <= in_ch.load_data;
      end
      if (in_ch.table_select == TSEL_ROW && in_ch.location[15:DIM_IDX_W] == '0) begin
        row_tab[in_ch.location[DIM_IDX_W-1:0]] <= in_ch.load_data;
      end
      if (in_ch.table_select == TSEL_PLANE && in_ch.location[15:PLANE_IDX_W] == '0) begin
        plane_tab[in_ch.location[PLANE_IDX_W-1:0]] <= in_ch.load_data;
      end
    end
  end

  // shared adder and helpers
  assign mult_full = tile_r * stride_r;

  always_comb begin
    unique case (state_r)
      S_ADDP:  add_b = prod_r;
      S_ADDC:  add_b = col_tab[ci_r];
      S_ADDR:  add_b = row_tab[y_r];
      S_PADDR: add_b = plane_tab[p_r];
      default: add_b = '0;
    endcase
  end

  assign sum      = acc_r + add_b;
  assign trial    = {5'd0, w_eff} << k_r;
  assign rem_step = ({5'd0, rem_r} >= trial) ? 6'({5'd0, rem_r} - trial) : rem_r;

  assign sh_full    = planes - 4'd1 - {1'b0, p_r};
  assign sh         = sh_full[2:0];
  assign bit_pos    = 3'd7 - addr_r[2:0];
  assign last_plane = ({1'b0, p_r} == planes - 4'd1);

  always_comb begin
    mod_byte          = rom_q_r;
    mod_byte[bit_pos] = pin_r[sh];
  end

  // ROM port
  assign rom_we = (in_xfer && in_ch.command == CMD_LOAD_ROM) ||
                  (state_r == S_PUSE && cmd_r == CMD_WRITE);
  assign rom_wa = (state_r == S_PUSE) ? addr_r[BIT_AW-1:3] : in_ch.location;
  assign rom_wd = (state_r == S_PUSE) ? mod_byte : in_ch.load_data[7:0];

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom_mem[rom_wa] <= rom_wd;
    end
    rom_q_r <= rom_mem[addr_r[BIT_AW-1:3]];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.command == CMD_LOAD_ROM || in_ch.command == CMD_LOAD_LAYOUT) begin
            state_nxt = S_DONE;
          end else if (planes == 4'd1 && quirk_r && in_ch.row == QUIRK_ROW) begin
            state_nxt = S_MOD;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MOD:   if (k_r == 3'd0) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_ADDP;
      S_ADDP:  state_nxt = S_ADDC;
      S_ADDC:  state_nxt = S_ADDR;
      S_ADDR:  state_nxt = S_PADDR;
      S_PADDR: state_nxt = S_PRD;
      S_PRD:   state_nxt = S_PUSE;
      S_PUSE:  state_nxt = last_plane ? S_DONE : S_PADDR;
      S_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          cmd_r  <= in_ch.command;
          tile_r <= in_ch.tile_index;
          x_r    <= in_ch.col;
          y_r    <= in_ch.row;
          pin_r  <= in_ch.pixel_in;
          ci_r   <= in_ch.col;
          rem_r  <= {1'b0, in_ch.col} + QUIRK_SHIFT;
          k_r    <= 3'd5;
          pix_r  <= 8'd0;
        end
      end
      S_MOD: begin
        rem_r <= rem_step;
        k_r   <= k_r - 3'd1;
        if (k_r == 3'd0) begin
          ci_r <= rem_step[DIM_IDX_W-1:0];
        end
      end
      S_MUL: begin
        prod_r <= mult_full[BIT_AW-1:0];
        acc_r  <= {base_r, 3'b000};
      end
      S_ADDP, S_ADDC: acc_r <= sum;
      S_ADDR: begin
        acc_r <= sum;
        p_r   <= '0;
      end
      S_PADDR: addr_r <= sum;
      S_PUSE: begin
        if (cmd_r == CMD_READ) begin
          pix_r[sh] <= rom_q_r[bit_pos];
        end
        p_r <= p_r + 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  ptpc_orient u_orient (
    .orientation (orient_r),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .x           (x_r),
    .y           (y_r),
    .dest_x      (dx),
    .dest_y      (dy)
  );

  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (cmd_r == CMD_LOAD_ROM || cmd_r == CMD_LOAD_LAYOUT) begin
        out_pix_r <= 8'd0;
        out_dx_r  <= 5'd0;
        out_dy_r  <= 5'd0;
      end else begin
        out_pix_r <= (cmd_r == CMD_READ) ? pix_r : 8'd0;
        out_dx_r  <= dx;
        out_dy_r  <= dy;
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.pixel_out = out_pix_r;
  assign out_ch.dest_x    = out_dx_r;
  assign out_ch.dest_y    = out_dy_r;

endmodule

`default_nettype wire

### sv/ptpc_orient.sv
// ----------------------------------------------------------------------------
// ptpc_orient
// Maps a source pixel position to its oriented destination in the tile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ptpc_orient import ptpc_pkg::*; (
  input  logic [2:0] orientation,
  input  logic [5:0] w_eff,
  input  logic [5:0] h_eff,
  input  logic [4:0] x,
  input  logic [4:0] y,
  output logic [4:0] dest_x,
  output logic [4:0] dest_y
);

  logic [5:0] wx_full;
  logic [5:0] hy_full;
  logic [4:0] wx;
  logic [4:0] hy;

  assign wx_full = w_eff - 6'd1 - {1'b0, x};
  assign hy_full = h_eff - 6'd1 - {1'b0, y};
  assign wx      = wx_full[4:0];
  assign hy      = hy_full[4:0];

  always_comb begin
    unique case (orientation)
      ORI_FLIPX: begin dest_x = wx; dest_y = y;  end
      ORI_FLIPY: begin dest_x = x;  dest_y = hy; end
      ORI_R180:  begin dest_x = wx; dest_y = hy; end
      ORI_R90:   begin dest_x = hy; dest_y = x;  end
      ORI_R270:  begin dest_x = y;  dest_y = wx; end
      default:   begin dest_x = x;  dest_y = y;  end
    endcase
  end

endmodule

`default_nettype wire

### sv/ptpc_checker.sv
// ----------------------------------------------------------------------------
// ptpc_checker
// Port-level checks of the pixel codec, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ptpc_checker import ptpc_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_command,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_pixel_out,
  input logic [4:0] out_dest_x,
  input logic [4:0] out_dest_y
);

  `PTPC_ASSERT_NEXT_NR(a_reset_idle, clk, !rst_n, !out_valid && in_ready)
  `PTPC_ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, in_valid && in_ready, !in_ready)
  `PTPC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixel_out) && $stable(out_dest_x) && $stable(out_dest_y))
  `PTPC_ASSERT_NEXT(a_load_result, clk, rst_n, in_valid && in_ready && !out_valid && (in_command == CMD_LOAD_ROM || in_command == CMD_LOAD_LAYOUT), ##1 (out_valid && out_pixel_out == 8'd0 && out_dest_x == 5'd0 && out_dest_y == 5'd0))

endmodule

bind planar_tile_pixel_codec_core ptpc_checker u_ptpc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_command    (in_ch.command),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_pixel_out (out_ch.pixel_out),
  .out_dest_x    (out_ch.dest_x),
  .out_dest_y    (out_ch.dest_y)
);

`default_nettype wire

### bench/planar_tile_pixel_codec_core_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_tile_pixel_codec_core_checker
// Watches the command, result and register ports of the tile pixel codec,
// keeps its own image of the ROM, layout tables and registers, predicts the
// pixel and destination of every accepted command and compares each result
// transfer with the oldest prediction.
// ----------------------------------------------------------------------------

module planar_tile_pixel_codec_core_checker import ptpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  ptpc_in_if                    in_ch,
  ptpc_out_if                   out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic [1:0]  command;
    logic [1:0]  table_select;
    logic [15:0] location;
    logic [18:0] load_data;
    logic [9:0]  tile_index;
    logic [4:0]  col;
    logic [4:0]  row;
    logic [7:0]  pixel_in;
  } tile_command_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic [4:0] dest_x;
    logic [4:0] dest_y;
  } pixel_result_t;

  logic [7:0]  rom_image   [0:ROM_BYTES-1];
  logic [18:0] col_table   [0:MAX_TILE_DIM-1];
  logic [18:0] row_table   [0:MAX_TILE_DIM-1];
  logic [18:0] plane_table [0:MAX_PLANES-1];

  logic [3:0]  plane_count;
  logic [18:0] tile_stride;
  logic [15:0] base_byte;
  logic [5:0]  tile_width;
  logic [5:0]  tile_height;
  logic [2:0]  orientation;
  logic        row4_quirk;

  pixel_result_t results_due[$];
  int errors = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  function automatic logic rom_bit(input logic [18:0] a);
    return rom_image[a[18:3]][3'd7 - a[2:0]];
  endfunction

  function automatic void set_rom_bit(input logic [18:0] a, input logic v);
    rom_image[a[18:3]][3'd7 - a[2:0]] = v;
  endfunction

  function automatic logic [5:0] dim_of(input logic [5:0] v);
    if (v == 6'd0) return 6'd1;
    if (v > 6'd32) return 6'd32;
    return v;
  endfunction

  function automatic pixel_result_t decode_tile_command(input tile_command_t c);
    pixel_result_t r;
    logic [3:0]    np;
    logic [5:0]    w;
    logic [5:0]    h;
    logic [18:0]   tile_bits;
    logic [18:0]   a;
    logic [4:0]    ci;
    logic [2:0]    sh;
    r  = '0;
    np = (plane_count == 4'd0) ? 4'd1 : (plane_count > 4'd8) ? 4'd8 : plane_count;
    w  = dim_of(tile_width);
    h  = dim_of(tile_height);
    if (c.command == CMD_LOAD_ROM) begin
      rom_image[c.location] = c.load_data[7:0];
      return r;
    end
    if (c.command == CMD_LOAD_LAYOUT) begin
      if (c.table_select == TSEL_COL && c.location < 16'd32)
        col_table[c.location[4:0]] = c.load_data;
      else if (c.table_select == TSEL_ROW && c.location < 16'd32)
        row_table[c.location[4:0]] = c.load_data;
      else if (c.table_select == TSEL_PLANE && c.location < 16'd8)
        plane_table[c.location[2:0]] = c.load_data;
      return r;
    end
    tile_bits = {base_byte, 3'b000} + c.tile_index * tile_stride;
    if (np == 4'd1 && row4_quirk) begin
      ci = (c.row == 5'd4) ? 5'((6'(c.col) + 6'd4) % w) : c.col;
      a  = tile_bits + col_table[ci] + row_table[c.row] + plane_table[0];
      if (c.command == CMD_READ) r.pixel[0] = rom_bit(a);
      else set_rom_bit(a, c.pixel_in[0]);
    end else begin
      for (int p = 0; p < np; p++) begin
        a  = tile_bits + col_table[c.col] + row_table[c.row] + plane_table[p];
        sh = 3'(np - 1 - p);
        if (c.command == CMD_READ) r.pixel[sh] = rom_bit(a);
        else set_rom_bit(a, c.pixel_in[sh]);
      end
    end
    case (orientation)
      ORI_FLIPX: begin
        r.dest_x = 5'(w - 6'd1 - c.col);
        r.dest_y = c.row;
      end
      ORI_FLIPY: begin
        r.dest_x = c.col;
        r.dest_y = 5'(h - 6'd1 - c.row);
      end
      ORI_R180: begin
        r.dest_x = 5'(w - 6'd1 - c.col);
        r.dest_y = 5'(h - 6'd1 - c.row);
      end
      ORI_R90: begin
        r.dest_x = 5'(h - 6'd1 - c.row);
        r.dest_y = c.col;
      end
      ORI_R270: begin
        r.dest_x = c.row;
        r.dest_y = 5'(w - 6'd1 - c.col);
      end
      default: begin
        r.dest_x = c.col;
        r.dest_y = c.row;
      end
    endcase
    return r;
  endfunction

  task automatic compare_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tile_command_t cmd;
    pixel_result_t due;
    if (!rst_n) begin
      plane_count = 4'd1;
      tile_stride = 19'd64;
      base_byte   = 16'd0;
      tile_width  = 6'd8;
      tile_height = 6'd8;
      orientation = ORI_NONE;
      row4_quirk  = 1'b0;
      results_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PLANE_COUNT: plane_count = cfg_data[3:0];
          REG_TILE_STRIDE: tile_stride = cfg_data[18:0];
          REG_BASE_BYTE:   base_byte   = cfg_data[15:0];
          REG_TILE_WIDTH:  tile_width  = cfg_data[5:0];
          REG_TILE_HEIGHT: tile_height = cfg_data[5:0];
          REG_ORIENTATION: orientation = cfg_data[2:0];
          REG_ROW4_QUIRK:  row4_quirk  = cfg_data[0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual pixel %0h dest %0d,%0d",
                   $time, out_ch.pixel_out, out_ch.dest_x, out_ch.dest_y);
        end else begin
          due = results_due.pop_front();
          compare_field("pixel_out", due.pixel, out_ch.pixel_out);
          compare_field("dest_x", due.dest_x, out_ch.dest_x);
          compare_field("dest_y", due.dest_y, out_ch.dest_y);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        cmd.command      = in_ch.command;
        cmd.table_select = in_ch.table_select;
        cmd.location     = in_ch.location;
        cmd.load_data    = in_ch.load_data;
        cmd.tile_index   = in_ch.tile_index;
        cmd.col          = in_ch.col;
        cmd.row          = in_ch.row;
        cmd.pixel_in     = in_ch.pixel_in;
        results_due.push_back(decode_tile_command(cmd));
      end
    end
    fail_count <= errors;
    pending    <= results_due.size();
  end

endmodule

### bench/planar_tile_pixel_codec_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_tile_pixel_codec_core_test
// Drives the tile pixel codec with ROM and layout loads and pixel reads and
// writes, under several register settings and idle/stall mixes. Every access
// is preceded by the loads it needs, so no unloaded byte or table entry is
// ever touched. A checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------

module planar_tile_pixel_codec_core_test;
  import ptpc_pkg::*;

  localparam int         CYCLE_LIMIT   = 1_000_000;
  localparam int         PHASES        = 8;
  localparam int         OPS_PER_PHASE = 60;
  localparam logic [1:0] TSEL_NONE     = 2'd3;
  localparam logic [2:0] ORI_SPARE6    = 3'd6;
  localparam logic [2:0] ORI_SPARE7    = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    in_idle_pct   = 0;
  int                    out_stall_pct = 0;
  int                    hold_left     = 0;
  int                    cycle_count   = 0;

  // what the stimulus has loaded so far
  bit          rom_loaded [0:ROM_BYTES-1];
  bit          col_set    [0:MAX_TILE_DIM-1];
  bit          row_set    [0:MAX_TILE_DIM-1];
  bit          plane_set  [0:MAX_PLANES-1];
  logic [18:0] col_off    [0:MAX_TILE_DIM-1];
  logic [18:0] row_off    [0:MAX_TILE_DIM-1];
  logic [18:0] plane_off  [0:MAX_PLANES-1];
  logic [3:0]  cur_planes;
  logic [18:0] cur_stride;
  logic [15:0] cur_base;
  logic [5:0]  cur_width;
  logic [5:0]  cur_height;
  logic        cur_quirk;
  logic [1:0]  last_cmd;
  logic [9:0]  last_tile;
  logic [4:0]  last_col;
  logic [4:0]  last_row;

  ptpc_in_if  in_ch();
  ptpc_out_if out_ch();

  planar_tile_pixel_codec_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  planar_tile_pixel_codec_core_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("planar_tile_pixel_codec_core_test: done, errors");
      $finish;
    end
  end

  function automatic int dim_span(input logic [5:0] v);
    if (v == 6'd0) return 1;
    if (v > 6'd32) return 32;
    return v;
  endfunction

  function automatic logic [18:0] random_offset();
    return ($urandom_range(0, 9) < 6) ? 19'($urandom_range(0, 63)) : 19'($urandom);
  endfunction

  task automatic send_command(input logic [1:0] cmd, input logic [1:0] sel,
                              input logic [15:0] loc, input logic [18:0] data,
                              input logic [9:0] tile, input logic [4:0] col,
                              input logic [4:0] row, input logic [7:0] pix);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.command      <= cmd;
    in_ch.table_select <= sel;
    in_ch.location     <= loc;
    in_ch.load_data    <= data;
    in_ch.tile_index   <= tile;
    in_ch.col          <= col;
    in_ch.row          <= row;
    in_ch.pixel_in     <= pix;
    in_ch.valid        <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic load_rom(input logic [15:0] loc, input logic [18:0] data);
    rom_loaded[loc] = 1'b1;
    send_command(CMD_LOAD_ROM, 2'($urandom), loc, data, 10'($urandom), 5'($urandom),
                 5'($urandom), 8'($urandom));
  endtask

  task automatic load_layout(input logic [1:0] sel, input logic [15:0] loc,
                             input logic [18:0] data);
    case (sel)
      TSEL_COL: if (loc < 16'd32) begin
        col_set[loc[4:0]] = 1'b1;
        col_off[loc[4:0]] = data;
      end
      TSEL_ROW: if (loc < 16'd32) begin
        row_set[loc[4:0]] = 1'b1;
        row_off[loc[4:0]] = data;
      end
      TSEL_PLANE: if (loc < 16'd8) begin
        plane_set[loc[2:0]] = 1'b1;
        plane_off[loc[2:0]] = data;
      end
      default: ;
    endcase
    send_command(CMD_LOAD_LAYOUT, sel, loc, data, 10'($urandom), 5'($urandom),
                 5'($urandom), 8'($urandom));
  endtask

  // load whatever table entries and ROM bytes the access touches, then issue it
  task automatic pixel_access(input logic [1:0] cmd, input logic [9:0] tile,
                              input logic [4:0] col, input logic [4:0] row,
                              input logic [7:0] pix);
    int          np;
    int          nused;
    logic        quirk;
    logic [4:0]  ci;
    logic [18:0] a;
    np    = (cur_planes == 4'd0) ? 1 : (cur_planes > 4'd8) ? 8 : cur_planes;
    quirk = (np == 1) && cur_quirk;
    nused = quirk ? 1 : np;
    ci    = (quirk && row == 5'd4) ? 5'((col + 4) % dim_span(cur_width)) : col;
    if (!col_set[ci]) load_layout(TSEL_COL, 16'(ci), random_offset());
    if (!row_set[row]) load_layout(TSEL_ROW, 16'(row), random_offset());
    for (int p = 0; p < nused; p++)
      if (!plane_set[p]) load_layout(TSEL_PLANE, 16'(p), random_offset());
    for (int p = 0; p < nused; p++) begin
      a = {cur_base, 3'b000} + tile * cur_stride + col_off[ci] + row_off[row] + plane_off[p];
      if (!rom_loaded[a[18:3]]) load_rom(a[18:3], 19'($urandom));
    end
    last_cmd  = cmd;
    last_tile = tile;
    last_col  = col;
    last_row  = row;
    send_command(cmd, 2'($urandom), 16'($urandom), 19'($urandom), tile, col, row, pix);
  endtask

  task automatic random_op();
    int         pick;
    logic [1:0] sel;
    logic [9:0] tile;
    logic [4:0] col;
    logic [4:0] row;
    pick = $urandom_range(0, 99);
    tile = ($urandom_range(0, 9) < 8) ? 10'($urandom_range(0, 3)) : 10'($urandom);
    col  = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, dim_span(cur_width) - 1))
                                      : 5'($urandom);
    row  = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, dim_span(cur_height) - 1))
                                      : 5'($urandom);
    if (pick < 60) begin
      pixel_access($urandom_range(0, 1) ? CMD_READ : CMD_WRITE, tile, col, row, 8'($urandom));
    end else if (pick < 75) begin
      pixel_access((last_cmd == CMD_READ) ? CMD_WRITE : CMD_READ, last_tile, last_col,
                   last_row, 8'($urandom));
    end else if (pick < 85) begin
      load_rom(16'($urandom), 19'($urandom));
    end else if (pick < 93) begin
      sel = 2'($urandom_range(0, 2));
      load_layout(sel, 16'($urandom_range(0, (sel == TSEL_PLANE) ? 7 : 31)), random_offset());
    end else begin
      case ($urandom_range(0, 2))
        0: load_layout(TSEL_NONE, 16'($urandom), 19'($urandom));
        1: load_layout($urandom_range(0, 1) ? TSEL_ROW : TSEL_COL,
                       16'($urandom_range(32, 65535)), 19'($urandom));
        default: load_layout(TSEL_PLANE, 16'($urandom_range(8, 65535)), 19'($urandom));
      endcase
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [18:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_we    <= 1'b1;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [3:0] planes, input logic [18:0] stride,
                            input logic [15:0] base, input logic [5:0] w,
                            input logic [5:0] h, input logic [2:0] ori, input logic quirk);
    write_reg(REG_PLANE_COUNT, 19'(planes));
    write_reg(REG_TILE_STRIDE, stride);
    write_reg(REG_BASE_BYTE, 19'(base));
    write_reg(REG_TILE_WIDTH, 19'(w));
    write_reg(REG_TILE_HEIGHT, 19'(h));
    write_reg(REG_ORIENTATION, 19'(ori));
    write_reg(REG_ROW4_QUIRK, 19'(quirk));
    cfg_we     <= 1'b0;
    cur_planes = planes;
    cur_stride = stride;
    cur_base   = base;
    cur_width  = w;
    cur_height = h;
    cur_quirk  = quirk;
  endtask

  // hold the sender until every outstanding result has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_PLANE_COUNT;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.command      <= CMD_LOAD_ROM;
    in_ch.table_select <= TSEL_COL;
    in_ch.location     <= '0;
    in_ch.load_data    <= '0;
    in_ch.tile_index   <= '0;
    in_ch.col          <= '0;
    in_ch.row          <= '0;
    in_ch.pixel_in     <= '0;
    last_cmd  = CMD_WRITE;
    last_tile = '0;
    last_col  = '0;
    last_row  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase % 4)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 87; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 87; end
        default: begin in_idle_pct = 27; out_stall_pct = 27; end
      endcase
      case (phase)
        0: set_config(4'd1, 19'd64, 16'd0, 6'd8, 6'd8, ORI_NONE, 1'b1);
        1: set_config(4'd8, 19'h7FFFF, 16'hFFFF, 6'd32, 6'd32, ORI_FLIPX, 1'b0);
        2: set_config(4'd0, 19'd0, 16'($urandom), 6'd1, 6'd1, ORI_R90, 1'b1);
        3: set_config(4'd15, 19'd256, 16'($urandom), 6'd63, 6'd0, ORI_R270, 1'b1);
        4: set_config(4'd4, 19'($urandom), 16'($urandom), 6'd16, 6'd8, ORI_FLIPY, 1'b0);
        5: set_config(4'd2, 19'd128, 16'd100, 6'd5, 6'd12, ORI_R180, 1'b0);
        6: set_config(4'd1, 19'd32, 16'($urandom), 6'd7, 6'd31, ORI_SPARE6, 1'b1);
        default: set_config(4'($urandom_range(1, 8)), 19'($urandom), 16'($urandom),
                            6'($urandom_range(1, 32)), 6'($urandom_range(1, 32)),
                            ORI_SPARE7, 1'($urandom));
      endcase
      if (phase == 0) begin
        load_rom(16'h0000, 19'h7FFFF);
        load_rom(16'hFFFF, 19'h00000);
        load_layout(TSEL_COL, 16'd31, 19'h7FFFF);
        load_layout(TSEL_ROW, 16'd31, 19'h00000);
        load_layout(TSEL_NONE, 16'hFFFF, 19'h7FFFF);
        load_layout(TSEL_COL, 16'd32, 19'h00005);
        load_layout(TSEL_PLANE, 16'd8, 19'h00001);
        pixel_access(CMD_WRITE, 10'd0, 5'd0, 5'd0, 8'hFF);
        pixel_access(CMD_READ, 10'd0, 5'd0, 5'd0, 8'h00);
        pixel_access(CMD_WRITE, 10'd0, 5'd6, 5'd4, 8'h01);
        pixel_access(CMD_READ, 10'd0, 5'd6, 5'd4, 8'h00);
        pixel_access(CMD_READ, 10'd0, 5'd2, 5'd3, 8'hFE);
        pixel_access(CMD_READ, 10'd0, 5'd20, 5'd4, 8'h55);
        pixel_access(CMD_WRITE, 10'h3FF, 5'd31, 5'd31, 8'h00);
        pixel_access(CMD_READ, 10'h3FF, 5'd31, 5'd31, 8'hFF);
        // long receiver hold while commands keep coming
        hold_left = 300;
        repeat (12) random_op();
        drain();
      end
      repeat (OPS_PER_PHASE) random_op();
      drain();
    end

    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("planar_tile_pixel_codec_core_test: done, clean");
    else
      $display("planar_tile_pixel_codec_core_test: done, errors");
    $finish;
  end

endmodule
